// ===== hw/rtl/b64d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, constants and functions of the base64 decoder
// Alphabet lookup, end-of-data check, phase codes and register map.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SYM_W  = 6;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned PADS_W = 2;
  localparam int unsigned VAR_W  = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register map: variant lives at byte address 0.
  localparam logic [ADDR_W-1:0] ADDR_VARIANT = 3'h0;

  // Variant register bits.
  localparam int unsigned VAR_URLSAFE = 0;
  localparam int unsigned VAR_NOPAD   = 1;

  localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D; // '='
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B; // '+'
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F; // '/'
  localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D; // '-'
  localparam logic [CHAR_W-1:0] CH_USCORE  = 8'h5F; // '_'
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

  localparam logic [CHAR_W-1:0] OFS_LOWER = 8'd26;
  localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'd52;
  localparam logic [SYM_W-1:0]  SYM_62    = 6'd62;
  localparam logic [SYM_W-1:0]  SYM_63    = 6'd63;

  typedef enum logic [1:0] {
    PH_DATA  = 2'd0,
    PH_PAD   = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] value;
  } sym_t;

  typedef struct packed {
    logic              err;
    phase_t            phase;
    logic [PADS_W-1:0] pads;
  } eod_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              msg_done;
    logic              status;
  } result_t;

  // Map a character to its six-bit value; hit low when outside the alphabet.
  function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] ch, input logic urlsafe);
    sym_t s;
    s.hit   = 1'b1;
    s.value = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      s.value = SYM_W'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      s.value = SYM_W'(ch - CH_LOWER_A + OFS_LOWER);
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      s.value = SYM_W'(ch - CH_DIGIT_0 + OFS_DIGIT);
    end else if (urlsafe && ch == CH_DASH) begin
      s.value = SYM_62;
    end else if (urlsafe && ch == CH_USCORE) begin
      s.value = SYM_63;
    end else if (!urlsafe && ch == CH_PLUS) begin
      s.value = SYM_62;
    end else if (!urlsafe && ch == CH_SLASH) begin
      s.value = SYM_63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // Close the data part: check the leftovers, pick padding or trailing.
  function automatic eod_t end_of_data(input logic [SYM_W-1:0]  lb,
                                       input logic [CNT_W-1:0]  lc,
                                       input logic [PADS_W-1:0] pads_in,
                                       input logic              nopad);
    eod_t       e;
    logic [7:0] mask;
    mask = (8'd1 << lc) - 8'd1;
    if (lc > CNT_W'(4) || (lb & mask[SYM_W-1:0]) != '0) begin
      e.err   = 1'b1;
      e.phase = PH_TRAIL;
      e.pads  = pads_in;
    end else if (!nopad && lc[2:1] != '0) begin
      e.err   = 1'b0;
      e.phase = PH_PAD;
      e.pads  = lc[2:1];
    end else begin
      e.err   = 1'b0;
      e.phase = PH_TRAIL;
      e.pads  = '0;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b64d_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_if: valid/ready stream channels of the base64 decoder
// Character channel in, decoded-byte channel out.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic                          valid;
  logic                          ready;
  logic [b64d_pkg::CHAR_W-1:0]   in_char;
  logic                          in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_out_if;
  logic                          valid;
  logic                          ready;
  logic                          byte_valid;
  logic [b64d_pkg::BYTE_W-1:0]   out_byte;
  logic                          msg_done;
  logic                          status;

  modport source (output valid, output byte_valid, output out_byte, output msg_done,
                  output status, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input msg_done,
                  input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/base64_stream_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming base64 decoder, one character a beat
// Standard or URL-safe alphabet, padded or unpadded, with message status.
// ----------------------------------------------------------------------------
// Feed one character per beat on din, with in_last on the final character of
// a message. Every input beat yields exactly one output beat on dout, in
// order: byte_valid/out_byte carry a decoded byte when one completes, and the
// beat for the last character has msg_done set and status 0 (well formed) or
// 1 (malformed). The block sustains one character per clock cycle while dout
// is ready; each character passes through an input register, then the result
// register. The one-character-per-cycle rate is set by the message state
// loop: lookup, bit gathering and padding check close through the state
// registers. The variant register (bit 0 URL-safe alphabet, bit 1 no padding
// expected) sits at APB byte address 0; write it only between messages while
// the stream is drained.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  b64d_in_if.sink                            din,
  b64d_out_if.source                         dout,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [b64d_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [b64d_pkg::DATA_W-1:0]   pwdata,
  output logic      [b64d_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  logic [b64d_pkg::VAR_W-1:0]  variant;

  // Input register stage.
  logic                        in_full;
  logic [b64d_pkg::CHAR_W-1:0] in_char_q;
  logic                        in_last_q;

  // Result register stage.
  logic                        out_full;
  b64d_pkg::result_t           out_q;
  b64d_pkg::result_t           step_res;

  logic                        out_load;
  logic                        step;

  b64d_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .variant (variant)
  );

  b64d_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .variant (variant),
    .in_char (in_char_q),
    .in_last (in_last_q),
    .res     (step_res)
  );

  // The result register may load when empty or being drained this cycle.
  assign out_load  = !out_full || dout.ready;
  // Advance the held character into the result register.
  assign step      = in_full && out_load;
  // Take a new character whenever the input register is empty or moving on.
  assign din.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (din.ready) begin
      in_full <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_char_q <= din.in_char;
      in_last_q <= din.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= step;
    end
  end

  // Hold the result while the sink stalls.
  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= step_res;
    end
  end

  assign dout.valid      = out_full;
  assign dout.byte_valid = out_q.byte_valid;
  assign dout.out_byte   = out_q.out_byte;
  assign dout.msg_done   = out_q.msg_done;
  assign dout.status     = out_q.status;

endmodule
`default_nettype wire

// ===== hw/rtl/b64d_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_cfg: APB register file of the base64 decoder
// Holds the variant register; zero wait states.
// ----------------------------------------------------------------------------
module b64d_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [b64d_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [b64d_pkg::DATA_W-1:0]   pwdata,
  output logic      [b64d_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [b64d_pkg::VAR_W-1:0]    variant
);

  logic sel_variant;

  // Low address bits are byte lanes; decode on the word index.
  assign sel_variant = (paddr[b64d_pkg::ADDR_W-1:2] ==
                        b64d_pkg::ADDR_VARIANT[b64d_pkg::ADDR_W-1:2]);
  assign pready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= '0;
    end else if (psel && penable && pwrite && pready && sel_variant) begin
      variant <= pwdata[b64d_pkg::VAR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_variant) begin
      prdata[b64d_pkg::VAR_W-1:0] = variant;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/b64d_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_step: per-character decode step and message state
// Lookup, bit gathering, padding tracking, sticky error, status at last.
// ----------------------------------------------------------------------------
module b64d_step (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [b64d_pkg::VAR_W-1:0]    variant,
  input  wire logic [b64d_pkg::CHAR_W-1:0]   in_char,
  input  wire logic                          in_last,
  output b64d_pkg::result_t                  res
);

  logic [b64d_pkg::SYM_W-1:0]  leftover_bits,  leftover_bits_next;
  logic [b64d_pkg::CNT_W-1:0]  leftover_count, leftover_count_next;
  b64d_pkg::phase_t            phase,          phase_next;
  logic [b64d_pkg::PADS_W-1:0] pads_owed,      pads_owed_next;
  logic                        error_seen,     error_seen_next;

  b64d_pkg::sym_t              sym;
  b64d_pkg::eod_t              eod;
  b64d_pkg::eod_t              eod_last;
  logic [2*b64d_pkg::SYM_W-1:0] acc;
  logic [3:0]                  cnt;
  logic [7:0]                  keep_mask;
  logic                        nopad;

  assign nopad = variant[b64d_pkg::VAR_NOPAD];
  assign sym   = b64d_pkg::sym_lookup(in_char, variant[b64d_pkg::VAR_URLSAFE]);
  assign acc   = {leftover_bits, sym.value};
  assign cnt   = 4'({1'b0, leftover_count}) + 4'd6;
  // Remaining count is cnt mod 8 whether or not a byte goes out.
  assign keep_mask = (8'd1 << cnt[2:0]) - 8'd1;
  assign eod   = b64d_pkg::end_of_data(leftover_bits, leftover_count, pads_owed, nopad);

  always_comb begin
    leftover_bits_next  = leftover_bits;
    leftover_count_next = leftover_count;
    phase_next          = phase;
    pads_owed_next      = pads_owed;
    error_seen_next     = error_seen;
    res                 = '0;
    eod_last            = '0;

    case (phase)
      b64d_pkg::PH_DATA: begin
        if (sym.hit) begin
          if (cnt[3]) begin
            res.byte_valid = 1'b1;
            res.out_byte   = 8'(acc >> cnt[2:0]);
          end
          leftover_count_next = cnt[2:0];
          leftover_bits_next  = acc[b64d_pkg::SYM_W-1:0] & keep_mask[b64d_pkg::SYM_W-1:0];
        end else begin
          // The ending character is the first padding candidate.
          phase_next     = eod.phase;
          pads_owed_next = eod.pads;
          if (eod.phase == b64d_pkg::PH_PAD) begin
            if (in_char == b64d_pkg::CH_PAD) begin
              pads_owed_next = eod.pads - 2'd1;
              if (eod.pads == 2'd1) begin
                phase_next = b64d_pkg::PH_TRAIL;
              end
            end else begin
              error_seen_next = 1'b1;
              phase_next      = b64d_pkg::PH_TRAIL;
            end
          end else begin
            error_seen_next = 1'b1;
          end
        end
      end
      b64d_pkg::PH_PAD: begin
        if (in_char == b64d_pkg::CH_PAD && pads_owed != '0) begin
          pads_owed_next = pads_owed - 2'd1;
          if (pads_owed == 2'd1) begin
            phase_next = b64d_pkg::PH_TRAIL;
          end
        end else begin
          error_seen_next = 1'b1;
          phase_next      = b64d_pkg::PH_TRAIL;
        end
      end
      default: begin
        error_seen_next = 1'b1;
      end
    endcase

    if (in_last) begin
      res.msg_done = 1'b1;
      if (phase_next == b64d_pkg::PH_DATA) begin
        eod_last = b64d_pkg::end_of_data(leftover_bits_next, leftover_count_next,
                                         pads_owed_next, nopad);
        if (eod_last.err || eod_last.phase == b64d_pkg::PH_PAD) begin
          error_seen_next = 1'b1;
        end
      end else if (phase_next == b64d_pkg::PH_PAD && pads_owed_next != '0) begin
        error_seen_next = 1'b1;
      end
      res.status = error_seen_next;
      // Drop all message state for the next one.
      leftover_bits_next  = '0;
      leftover_count_next = '0;
      phase_next          = b64d_pkg::PH_DATA;
      pads_owed_next      = '0;
      error_seen_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
      phase          <= b64d_pkg::PH_DATA;
      pads_owed      <= '0;
      error_seen     <= 1'b0;
    end else if (step) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
      phase          <= phase_next;
      pads_owed      <= pads_owed_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/b64d_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks of the base64 decoder
// Beat accounting and result field consistency, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          byte_valid,
  input wire logic [b64d_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                          msg_done,
  input wire logic                          status
);

  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pending_next = pending;
    if (in_beat && !out_beat) begin
      pending_next = pending + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_next = pending - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  // No result beat without a character still owed one.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result beat with no outstanding character");

  // At most two characters in flight: input and result registers.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more characters in flight than pipeline stages");

  // Status only speaks on the last beat of a message.
  a_status_at_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !msg_done |-> !status)
    else $error("status set on a beat that is not the last");

  // A beat without a byte carries a zero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == '0)
    else $error("out_byte nonzero without byte_valid");

  // Nothing shows on the output right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .byte_valid (dout.byte_valid),
  .out_byte   (dout.out_byte),
  .msg_done   (dout.msg_done),
  .status     (dout.status)
);
`default_nettype wire
